// ===== src/upd_pkg.sv =====
// Package for the URL percent decoder: character codes, queue sizing,
// the command type passed from front to back, and hex helpers. No dependencies.
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam int MAX_BYTES   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(MAX_BYTES);
    localparam int NUM_W       = $clog2(MAX_BYTES + 1);

    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PERCENT = 2'd1;
    localparam logic [1:0] HELD_DIGIT   = 2'd2;

    typedef struct packed {
        logic [NUM_W-1:0]          num;
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic                      last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        cmd_t head;
    } queue_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        if (c <= CH_NINE)
            v = c[3:0];
        else
            v = c[3:0] + 4'd9;
        return v;
    endfunction

endpackage

// ===== src/upd_front.sv =====
// Front end of the URL percent decoder: classifies each input byte, tracks
// the held percent and digit, and pushes output commands. Uses upd_pkg.
module upd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic          queue_full,
    output logic          push,
    output upd_pkg::cmd_t cmd
);
    import upd_pkg::*;

    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic       accept;
    logic       b_hex;
    logic       do_fresh;
    logic       f_emit;
    logic [7:0] f_byte;
    logic [1:0] f_held;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign b_hex    = is_hex(in_byte);

    always_comb
    begin
        f_emit = 1'b1;
        f_byte = in_byte;
        f_held = HELD_NONE;
        if (in_byte == CH_PERCENT)
        begin
            if (!in_last)
            begin
                f_emit = 1'b0;
                f_held = HELD_PERCENT;
            end
        end
        else if (in_byte == CH_PLUS)
        begin
            f_byte = CH_SPACE;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.last        = in_last;
        do_fresh        = 1'b0;
        held_count_next = HELD_NONE;
        held_digit_next = held_digit_reg;
        unique case (held_count_reg)
            HELD_PERCENT:
            begin
                if (b_hex && !in_last)
                begin
                    held_count_next = HELD_DIGIT;
                    held_digit_next = in_byte;
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.num      = NUM_W'(1);
                    do_fresh     = 1'b1;
                end
            end
            HELD_DIGIT:
            begin
                held_digit_next = '0;
                if (b_hex)
                begin
                    cmd.bytes[0] = {hex_nibble(held_digit_reg), hex_nibble(in_byte)};
                    cmd.num      = NUM_W'(1);
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = held_digit_reg;
                    cmd.num      = NUM_W'(2);
                    do_fresh     = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase
        if (do_fresh)
        begin
            held_count_next = f_held;
            if (f_emit)
            begin
                cmd.bytes[cmd.num[IDX_W-1:0]] = f_byte;
                cmd.num = cmd.num + NUM_W'(1);
            end
        end
    end

    assign push = accept && (cmd.num != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= HELD_NONE;
            held_digit_reg <= '0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            held_digit_reg <= held_digit_next;
        end
    end

endmodule

// ===== src/upd_queue.sv =====
// Short command queue between the decoder front and back ends.
// Uses upd_pkg for the command type and depth.
module upd_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  upd_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output logic                   full,
    output upd_pkg::queue_status_t status
);
    import upd_pkg::*;

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full         = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head  = entries_reg[rd_ptr_reg];
    assign do_pop       = pop && !status.empty;

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (!push && do_pop)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== src/upd_back.sv =====
// Back end of the URL percent decoder: walks the bytes of the head command
// into the output register, one per cycle while out_ready does not stall it. Uses upd_pkg.
module upd_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  upd_pkg::queue_status_t status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);
    import upd_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             load;
    logic             final_byte;

    assign load       = !out_valid_reg || out_ready;
    assign final_byte = (NUM_W'(idx_reg) + NUM_W'(1)) == status.head.num;
    assign pop        = load && !status.empty && final_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (load && !status.empty)
        begin
            out_byte_reg <= status.head.bytes[idx_reg];
            out_last_reg <= status.head.last && final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= !status.empty;
            if (!status.empty)
            begin
                if (final_byte)
                    idx_reg <= '0;
                else
                    idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

endmodule

// ===== src/url_percent_decoder_top.sv =====
// Path: an accepted input byte's command is written into a queue entry, then its first
// output byte is loaded into the output register and offered on m_tdata.
// Throughput: one input byte per cycle while each byte yields at most one
// output byte and m_tready is high; the output register drains one byte per cycle
// while m_tready is high; two- and three-byte flushes back up the four-entry queue.
// Reset: rst_n asynchronous, active low; clears held state, queue and output.
// Top level of the URL percent decoder; uses upd_pkg, upd_front, upd_queue, upd_back.
module url_percent_decoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);
    import upd_pkg::*;

    cmd_t          cmd;
    logic          push;
    logic          pop;
    logic          queue_full;
    queue_status_t status;

    upd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (cmd)
    );

    upd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .full     (queue_full),
        .status   (status)
    );

    upd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== src/upd_checker.sv =====
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder_top port names only.
module upd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    logic [3:0] open_strings_reg;
    logic       in_end;
    logic       out_end;

    assign in_end  = s_tvalid && s_tready && s_tlast;
    assign out_end = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_strings_reg <= '0;
        else if (in_end && !out_end)
            open_strings_reg <= open_strings_reg + 4'd1;
        else if (!in_end && out_end)
            open_strings_reg <= open_strings_reg - 4'd1;
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !s_tvalid |=> s_tready)
        else $error("input ready dropped without a transaction");

    a_last_matched: assert property (@(posedge clk) disable iff (!rst_n)
        out_end |-> open_strings_reg != 4'd0)
        else $error("output last without a matching input last");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (.*);
